/* hdl/ascii_motion_command_parser_defines.svh */
// assertion macros for the ascii motion command parser checks
`ifndef ASCII_MOTION_COMMAND_PARSER_DEFINES_SVH
`define ASCII_MOTION_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ascii motion parser check failed");

// next-cycle implication
`define AMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ascii motion parser check failed");

`endif

/* hdl/ampar_pkg.sv */
// shared types, constants and keyword lookup for the ascii motion command parser
package ampar_pkg;

  localparam int LINE_CAPACITY_DEF = 64;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam int VALUE_W = 16;
  localparam int KW_CHARS_W = 40;
  localparam int KW_LEN_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEF_DRIVE_PWM = 10'd400;
  localparam logic [CFG_DATA_W-1:0] DEF_TURN_PWM = 10'd300;

  localparam logic [KW_LEN_W-1:0] KW_MAX = 4'd5;
  localparam logic [KW_LEN_W-1:0] KW_TOO_LONG = 4'd6;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [KW_CHARS_W-1:0] KW_STOP = 40'h00_5354_4F50;
  localparam logic [KW_CHARS_W-1:0] KW_FWD = 40'h00_0046_5744;
  localparam logic [KW_CHARS_W-1:0] KW_BACK = 40'h00_4241_434B;
  localparam logic [KW_CHARS_W-1:0] KW_LEFT = 40'h00_4C45_4654;
  localparam logic [KW_CHARS_W-1:0] KW_RIGHT = 40'h52_4947_4854;
  localparam logic [KW_CHARS_W-1:0] KW_VEL = 40'h00_0056_454C;
  localparam logic [KW_CHARS_W-1:0] KW_ESTOP = 40'h45_5354_4F50;
  localparam logic [KW_CHARS_W-1:0] KW_HEAD = 40'h00_4845_4144;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_HALT  = 4'd1,
    CMD_FWD   = 4'd2,
    CMD_BACK  = 4'd3,
    CMD_LEFT  = 4'd4,
    CMD_RIGHT = 4'd5,
    CMD_VEL   = 4'd6,
    CMD_ESTOP = 4'd7,
    CMD_HEAD  = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_KEY  = 3'd1,
    PH_GAP1 = 3'd2,
    PH_ARG1 = 3'd3,
    PH_GAP2 = 3'd4,
    PH_ARG2 = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    SC_OFF = 2'd0,
    SC_WS  = 2'd1,
    SC_POS = 2'd2,
    SC_NEG = 2'd3
  } scan_e;

  typedef struct packed {
    scan_e              st;
    logic [VALUE_W-1:0] acc;
    logic               nz;
  } scan_t;

  function automatic cmd_e kw_lookup(input logic [KW_CHARS_W-1:0] chars,
                                     input logic [KW_LEN_W-1:0] len);
    cmd_e id;
    id = CMD_NONE;
    if (len == 4'd4 && chars == KW_STOP) id = CMD_HALT;
    else if (len == 4'd3 && chars == KW_FWD) id = CMD_FWD;
    else if (len == 4'd4 && chars == KW_BACK) id = CMD_BACK;
    else if (len == 4'd4 && chars == KW_LEFT) id = CMD_LEFT;
    else if (len == 4'd5 && chars == KW_RIGHT) id = CMD_RIGHT;
    else if (len == 4'd3 && chars == KW_VEL) id = CMD_VEL;
    else if (len == 4'd5 && chars == KW_ESTOP) id = CMD_ESTOP;
    else if (len == 4'd4 && chars == KW_HEAD) id = CMD_HEAD;
    return id;
  endfunction

endpackage

/* hdl/ascii_motion_command_parser.sv */
// top level of the ascii motion command parser: line state, keyword match, result register
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   rx_byte_i
// out      out  out_valid_o / out_ready_i command_id_o, first_value_o, second_value_o
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one word per cycle while in_ready_o is high; the line state updates in the accepting cycle
// a result shows on the output register the cycle after its CR or LF word
// in_ready_o is low only while a result waits and out_ready_i is low
// reset clears the line state and loads the default pwm values; no clearing pass
module ascii_motion_command_parser #(
  parameter int LINE_CAPACITY = ampar_pkg::LINE_CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [3:0]                          command_id_o,
  output logic signed [ampar_pkg::VALUE_W-1:0] first_value_o,
  output logic signed [ampar_pkg::VALUE_W-1:0] second_value_o,
  input  logic                                cfg_we_i,
  input  logic [ampar_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ampar_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import ampar_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  logic [CFG_DATA_W-1:0] drive_q;
  logic [CFG_DATA_W-1:0] turn_q;

  logic [LEN_W-1:0]      len_q, len_d;
  phase_e                phase_q, phase_d;
  logic [KW_CHARS_W-1:0] kw_q, kw_d;
  logic [KW_LEN_W-1:0]   kw_len_q, kw_len_d;
  logic [VALUE_W-1:0]    acc1_q, acc1_d;
  logic [VALUE_W-1:0]    acc2_q, acc2_d;
  scan_e                 sc1_q, sc1_d;
  scan_e                 sc2_q, sc2_d;
  logic                  nz_q, nz_d;
  logic                  ended_q, ended_d;

  logic                  out_valid_q, out_valid_d;
  cmd_e                  cmd_q;
  logic [VALUE_W-1:0]    val1_q, val2_q;

  logic                  accept;
  logic                  is_eol;
  logic                  is_blank;
  scan_e                 sc1_in, sc2_in;
  scan_t                 sc1_res, sc2_res;
  cmd_e                  cmd_id;
  logic                  hit;
  logic [VALUE_W-1:0]    val1;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_eol     = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);
  assign is_blank   = (rx_byte_i == CH_SP) || (rx_byte_i == CH_TAB);

  assign sc1_in = (phase_q == PH_GAP1 && !is_blank) ? SC_WS : sc1_q;
  assign sc2_in = (phase_q == PH_GAP2 && !is_blank) ? SC_WS : sc2_q;

  ampar_scan u_scan1 (
    .st_i  (sc1_in),
    .acc_i (acc1_q),
    .c_i   (rx_byte_i),
    .res_o (sc1_res)
  );

  ampar_scan u_scan2 (
    .st_i  (sc2_in),
    .acc_i (acc2_q),
    .c_i   (rx_byte_i),
    .res_o (sc2_res)
  );

  assign cmd_id = kw_lookup(kw_q, kw_len_q);
  assign hit    = accept && is_eol && (len_q != '0) && (cmd_id != CMD_NONE);

  always_comb begin
    val1 = acc1_q;
    if (!nz_q) begin
      if (cmd_id == CMD_FWD || cmd_id == CMD_BACK) begin
        val1 = {{(VALUE_W-CFG_DATA_W){1'b0}}, drive_q};
      end else if (cmd_id == CMD_LEFT || cmd_id == CMD_RIGHT) begin
        val1 = {{(VALUE_W-CFG_DATA_W){1'b0}}, turn_q};
      end
    end
  end

  always_comb begin
    len_d    = len_q;
    phase_d  = phase_q;
    kw_d     = kw_q;
    kw_len_d = kw_len_q;
    acc1_d   = acc1_q;
    acc2_d   = acc2_q;
    sc1_d    = sc1_q;
    sc2_d    = sc2_q;
    nz_d     = nz_q;
    ended_d  = ended_q;
    if (accept) begin
      if (is_eol) begin
        if (len_q != '0) begin
          len_d    = '0;
          phase_d  = PH_LEAD;
          kw_d     = '0;
          kw_len_d = '0;
          acc1_d   = '0;
          acc2_d   = '0;
          sc1_d    = SC_OFF;
          sc2_d    = SC_OFF;
          nz_d     = 1'b0;
          ended_d  = 1'b0;
        end
      end else if (len_q < LEN_MAX) begin
        len_d = len_q + 1'b1;
        if (!ended_q) begin
          if (rx_byte_i == CH_NUL) begin
            ended_d = 1'b1;
          end else begin
            sc1_d  = sc1_res.st;
            acc1_d = sc1_res.acc;
            nz_d   = nz_q || sc1_res.nz;
            sc2_d  = sc2_res.st;
            acc2_d = sc2_res.acc;
            if ((phase_q == PH_LEAD || phase_q == PH_KEY) && !is_blank) begin
              if (kw_len_q < KW_MAX) begin
                kw_d     = {kw_q[KW_CHARS_W-9:0], rx_byte_i};
                kw_len_d = kw_len_q + 1'b1;
              end else begin
                kw_len_d = KW_TOO_LONG;
              end
            end
            unique case (phase_q)
              PH_LEAD: if (!is_blank) phase_d = PH_KEY;
              PH_KEY:  if (is_blank) phase_d = PH_GAP1;
              PH_GAP1: if (!is_blank) phase_d = PH_ARG1;
              PH_ARG1: if (is_blank) phase_d = PH_GAP2;
              PH_GAP2: if (!is_blank) phase_d = PH_ARG2;
              PH_ARG2: phase_d = PH_ARG2;
              default: phase_d = PH_LEAD;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= DEF_DRIVE_PWM;
      turn_q  <= DEF_TURN_PWM;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DRIVE) begin
        drive_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_TURN) begin
        turn_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      phase_q     <= PH_LEAD;
      kw_q        <= '0;
      kw_len_q    <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      sc1_q       <= SC_OFF;
      sc2_q       <= SC_OFF;
      nz_q        <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      phase_q     <= phase_d;
      kw_q        <= kw_d;
      kw_len_q    <= kw_len_d;
      acc1_q      <= acc1_d;
      acc2_q      <= acc2_d;
      sc1_q       <= sc1_d;
      sc2_q       <= sc2_d;
      nz_q        <= nz_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      cmd_q  <= cmd_id;
      val1_q <= val1;
      val2_q <= acc2_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_id_o   = cmd_q;
  assign first_value_o  = val1_q;
  assign second_value_o = val2_q;

endmodule

/* hdl/ampar_scan.sv */
// one step of the decimal argument scanner: blank skip, sign, digits mod 2^16
module ampar_scan (
  input  ampar_pkg::scan_e                 st_i,
  input  logic [ampar_pkg::VALUE_W-1:0]    acc_i,
  input  logic [7:0]                       c_i,
  output ampar_pkg::scan_t                 res_o
);
  import ampar_pkg::*;

  logic               is_digit;
  logic               is_ws;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] acc_x10;
  logic [VALUE_W-1:0] acc_pos;
  logic [VALUE_W-1:0] acc_neg;

  assign is_digit = (c_i >= CH_ZERO) && (c_i <= CH_NINE);
  assign is_ws    = (c_i == CH_SP) || ((c_i >= CH_TAB) && (c_i <= CH_CR));
  assign digit    = c_i[3:0];
  assign acc_x10  = {acc_i[VALUE_W-4:0], 3'b000} + {acc_i[VALUE_W-2:0], 1'b0};
  assign acc_pos  = acc_x10 + {{(VALUE_W-4){1'b0}}, digit};
  assign acc_neg  = acc_x10 - {{(VALUE_W-4){1'b0}}, digit};

  always_comb begin
    res_o.st  = SC_OFF;
    res_o.acc = acc_i;
    res_o.nz  = 1'b0;
    unique case (st_i)
      SC_OFF: begin
        res_o.st = SC_OFF;
      end
      SC_WS: begin
        if (is_ws) begin
          res_o.st = SC_WS;
        end else if (c_i == CH_PLUS) begin
          res_o.st = SC_POS;
        end else if (c_i == CH_MINUS) begin
          res_o.st = SC_NEG;
        end else if (is_digit) begin
          res_o.st  = SC_POS;
          res_o.acc = acc_pos;
          res_o.nz  = (digit != 4'd0);
        end
      end
      SC_POS, SC_NEG: begin
        if (is_digit) begin
          res_o.st  = st_i;
          res_o.acc = (st_i == SC_POS) ? acc_pos : acc_neg;
          res_o.nz  = (digit != 4'd0);
        end
      end
      default: begin
        res_o.st = SC_OFF;
      end
    endcase
  end

endmodule

/* hdl/ampar_checker.sv */
// port-level checks for the ascii motion command parser, bound to the top level
`include "ascii_motion_command_parser_defines.svh"

module ampar_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [7:0]                    rx_byte_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [3:0]                    command_id_o,
  input logic [ampar_pkg::VALUE_W-1:0] first_value_o
);
  import ampar_pkg::*;

  // a waiting result holds
  `AMP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `AMP_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(command_id_o) && $stable(first_value_o))

  // only known command ids
  `AMP_ASSERT_SAME(a_id_range, out_valid_o, (command_id_o >= CMD_HALT) && (command_id_o <= CMD_HEAD))

  // a fresh result follows an accepted line end word
  `AMP_ASSERT_SAME(a_new_after_eol, out_valid_o && !$past(out_valid_o && !out_ready_i), $past(in_valid_i && in_ready_o && (rx_byte_i == CH_CR || rx_byte_i == CH_LF)))

  // no stall without a waiting result
  `AMP_ASSERT_SAME(a_ready_when_empty, !out_valid_o, in_ready_o)

endmodule

bind ascii_motion_command_parser ampar_checker u_ampar_checker (.*);

/* bench/ascii_motion_command_parser_tb.sv */
// self-checking bench for the ascii motion command parser: directed lines, random lines, scoreboard
`timescale 1ns / 1ps

module ascii_motion_command_parser_tb;
  import ampar_pkg::*;

  localparam int LINE_CAP = LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BYTES = 670;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED = 24;

  typedef struct packed {
    cmd_e                       id;
    logic signed [VALUE_W-1:0] arg1;
    logic signed [VALUE_W-1:0] arg2;
  } motion_cmd_t;

  typedef enum {ROW_NONE, ROW_LIT, ROW_MODEL} row_kind_e;

  typedef struct {
    string      head;
    logic [7:0] pad_ch;
    int         pad_n;
    string      tail;
    logic [7:0] term;
    row_kind_e  kind;
    cmd_e       id;
    int         v1;
    int         v2;
  } line_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [7:0]                 rx_byte_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [3:0]                 command_id_o;
  logic signed [VALUE_W-1:0]  first_value_o;
  logic signed [VALUE_W-1:0]  second_value_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;

  ascii_motion_command_parser dut (.*);

  always #2 clk_i = ~clk_i;

  motion_cmd_t expected_cmds[$];
  line_row_t   directed_lines[N_DIRECTED];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 32;
  int          recv_idle_pct = 68;
  int          hold_left = 0;
  bit          long_hold_req = 1'b0;

  logic [$clog2(LINE_CAP)-1:0] line_len;
  phase_e                      ph;
  logic [KW_CHARS_W-1:0]       kw_chars;
  logic [KW_LEN_W-1:0]         kw_len;
  logic [VALUE_W-1:0]          acc1;
  logic [VALUE_W-1:0]          acc2;
  scan_e                       sc1;
  scan_e                       sc2;
  logic                        nz1;
  logic                        text_done;
  logic [CFG_DATA_W-1:0]       drive_pwm;
  logic [CFG_DATA_W-1:0]       turn_pwm;

  string cmd_names[8] = '{"STOP", "FWD", "BACK", "LEFT", "RIGHT", "VEL", "ESTOP", "HEAD"};
  cmd_e  cmd_codes[8] = '{CMD_HALT, CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_VEL,
                          CMD_ESTOP, CMD_HEAD};

  function automatic void clear_line();
    line_len = '0;
    ph = PH_LEAD;
    kw_chars = '0;
    kw_len = '0;
    acc1 = '0;
    acc2 = '0;
    sc1 = SC_OFF;
    sc2 = SC_OFF;
    nz1 = 1'b0;
    text_done = 1'b0;
  endfunction

  task automatic scan_step(inout scan_e st, inout logic [VALUE_W-1:0] acc, inout logic nz,
                           input logic [7:0] c);
    logic       digit;
    logic       take;
    logic [3:0] d;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = c[3:0];
    take = 1'b0;
    case (st)
      SC_WS: begin
        if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) st = SC_WS;
        else if (c == CH_PLUS) st = SC_POS;
        else if (c == CH_MINUS) st = SC_NEG;
        else if (digit) begin
          st = SC_POS;
          take = 1'b1;
        end else st = SC_OFF;
      end
      SC_POS, SC_NEG: begin
        if (digit) take = 1'b1;
        else st = SC_OFF;
      end
      default: ;
    endcase
    if (take) begin
      if (d != 4'd0) nz = 1'b1;
      if (st == SC_POS) acc = VALUE_W'(acc * 10 + d);
      else acc = VALUE_W'(acc * 10 - d);
    end
  endtask

  task automatic add_key_char(input logic [7:0] c);
    if (kw_len < KW_MAX) begin
      kw_chars = {kw_chars[KW_CHARS_W-9:0], c};
      kw_len = kw_len + 1'b1;
    end else begin
      kw_len = KW_TOO_LONG;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic blank;
    logic nz2;
    blank = (c == CH_SP) || (c == CH_TAB);
    nz2 = 1'b0;
    if (sc1 != SC_OFF) scan_step(sc1, acc1, nz1, c);
    if (sc2 != SC_OFF) scan_step(sc2, acc2, nz2, c);
    case (ph)
      PH_LEAD: begin
        if (!blank) begin
          ph = PH_KEY;
          add_key_char(c);
        end
      end
      PH_KEY: begin
        if (blank) ph = PH_GAP1;
        else add_key_char(c);
      end
      PH_GAP1: begin
        if (!blank) begin
          ph = PH_ARG1;
          sc1 = SC_WS;
          scan_step(sc1, acc1, nz1, c);
        end
      end
      PH_ARG1: begin
        if (blank) ph = PH_GAP2;
      end
      PH_GAP2: begin
        if (!blank) begin
          ph = PH_ARG2;
          sc2 = SC_WS;
          scan_step(sc2, acc2, nz2, c);
        end
      end
      default: ;
    endcase
  endtask

  function automatic cmd_e keyword_command();
    cmd_e                  id;
    logic [KW_CHARS_W-1:0] name_bits;
    string                 s;
    int                    i;
    int                    j;
    id = CMD_NONE;
    for (i = 0; i < 8; i++) begin
      s = cmd_names[i];
      name_bits = '0;
      for (j = 0; j < s.len(); j++) name_bits = {name_bits[KW_CHARS_W-9:0], s[j]};
      if (id == CMD_NONE && kw_len == s.len() && name_bits == kw_chars) id = cmd_codes[i];
    end
    return id;
  endfunction

  task automatic parse_byte(input logic [7:0] c, output bit got, output motion_cmd_t cmd);
    cmd_e id;
    got = 1'b0;
    cmd = '0;
    if (c == CH_CR || c == CH_LF) begin
      if (line_len != 0) begin
        id = keyword_command();
        if (id != CMD_NONE) begin
          got = 1'b1;
          cmd.id = id;
          cmd.arg1 = acc1;
          cmd.arg2 = acc2;
          if (!nz1) begin
            if (id == CMD_FWD || id == CMD_BACK) cmd.arg1 = VALUE_W'(drive_pwm);
            else if (id == CMD_LEFT || id == CMD_RIGHT) cmd.arg1 = VALUE_W'(turn_pwm);
          end
        end
        clear_line();
      end
    end else if (line_len < LINE_CAP - 1) begin
      line_len = line_len + 1'b1;
      if (!text_done) begin
        if (c == CH_NUL) text_done = 1'b1;
        else take_char(c);
      end
    end
  endtask

  task automatic offer_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] c, input bit keep);
    bit          got;
    motion_cmd_t cmd;
    parse_byte(c, got, cmd);
    if (got && keep) expected_cmds.push_back(cmd);
    offer_byte(c);
  endtask

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  task automatic random_line();
    logic [7:0] q[$];
    string      s;
    int         k;
    int         n;
    int         nd;
    int         a;
    int         j;
    bit         lower;
    bit         all_zero;
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 24);
      repeat (n) q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) q.push_back(blank_char());
      s = cmd_names[$urandom_range(7)];
      k = $urandom_range(99);
      lower = (k >= 94);
      for (j = 0; j < s.len(); j++) q.push_back(lower ? (s[j] | 8'h20) : s[j]);
      if (k >= 80 && k < 88) begin
        q[q.size() - 1 - $urandom_range(s.len() - 1)] = 8'(65 + $urandom_range(25));
      end else if (k >= 88 && k < 94) begin
        q.push_back(8'(65 + $urandom_range(25)));
      end
      n = $urandom_range(3);
      for (a = 0; a < n; a++) begin
        repeat ($urandom_range(1, 2)) q.push_back(blank_char());
        if ($urandom_range(19) == 0) repeat ($urandom_range(40, 60)) q.push_back(CH_SP);
        if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(11, 12)));
        case ($urandom_range(3))
          0: q.push_back(CH_PLUS);
          1: q.push_back(CH_MINUS);
          default: ;
        endcase
        nd = $urandom_range(6);
        all_zero = ($urandom_range(5) == 0);
        repeat (nd) q.push_back(all_zero ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(33, 126)));
      end
      if ($urandom_range(19) == 0) q.insert($urandom_range(q.size() - 1), CH_NUL);
    end
    q.push_back($urandom_range(1) ? CH_CR : CH_LF);
    if ($urandom_range(4) == 0) q.push_back(CH_LF);
    for (j = 0; j < q.size(); j++) feed(q[j], 1'b1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit hold,
                           input logic [CFG_DATA_W-1:0] drive, input logic [CFG_DATA_W-1:0] turn);
    int start;
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DRIVE;
    cfg_wdata_i <= drive;
    @(posedge clk_i);
    cfg_idx_i <= CFG_TURN;
    cfg_wdata_i <= turn;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drive_pwm = drive;
    turn_pwm = turn;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    long_hold_req = hold;
    @(posedge clk_i);
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_line();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    motion_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        $error("command_id: expected none, got %0d", command_id_o);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (command_id_o !== want.id) begin
          $error("command_id: expected %0d, got %0d", want.id, command_id_o);
          mismatches++;
        end
        if (first_value_o !== want.arg1) begin
          $error("first_value: expected %0d, got %0d", want.arg1, first_value_o);
          mismatches++;
        end
        if (second_value_o !== want.arg2) begin
          $error("second_value: expected %0d, got %0d", want.arg2, second_value_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    line_row_t   r;
    motion_cmd_t lit;
    bit          keep;
    int          i;
    int          j;
    drive_pwm = DEF_DRIVE_PWM;
    turn_pwm = DEF_TURN_PWM;
    clear_line();
    directed_lines = '{
      '{"STOP", CH_SP, 0, "", CH_LF, ROW_LIT, CMD_HALT, 0, 0},
      '{"FWD", CH_SP, 0, "", CH_CR, ROW_LIT, CMD_FWD, 400, 0},
      '{"BACK 0 9", CH_SP, 0, "", CH_LF, ROW_LIT, CMD_BACK, 400, 9},
      '{"LEFT -0", CH_SP, 0, "", CH_CR, ROW_LIT, CMD_LEFT, 300, 0},
      '{"RIGHT 000 -5", CH_SP, 0, "", CH_LF, ROW_LIT, CMD_RIGHT, 300, -5},
      '{"VEL 32767 -32768", CH_SP, 0, "", CH_LF, ROW_LIT, CMD_VEL, 32767, -32768},
      '{"HEAD 65536 70000", CH_SP, 0, "", CH_CR, ROW_LIT, CMD_HEAD, 0, 4464},
      '{"ESTOP +12abc -7x", CH_SP, 0, "", CH_LF, ROW_LIT, CMD_ESTOP, 12, -7},
      '{" \t FWD\t 7  8  9", CH_SP, 0, "", CH_LF, ROW_MODEL, CMD_NONE, 0, 0},
      '{"STOPX", CH_SP, 0, "", CH_LF, ROW_NONE, CMD_NONE, 0, 0},
      '{"RIGHTS 5", CH_SP, 0, "", CH_CR, ROW_NONE, CMD_NONE, 0, 0},
      '{"", CH_SP, 0, "", CH_LF, ROW_NONE, CMD_NONE, 0, 0},
      '{" \t ", CH_SP, 0, "", CH_CR, ROW_NONE, CMD_NONE, 0, 0},
      '{"fwd 1", CH_SP, 0, "", CH_LF, ROW_NONE, CMD_NONE, 0, 0},
      '{"STOP", 8'hFF, 1, "", CH_LF, ROW_NONE, CMD_NONE, 0, 0},
      '{"FWD 5", CH_NUL, 1, " 9", CH_LF, ROW_LIT, CMD_FWD, 5, 0},
      '{"VEL 1", CH_SP, 60, "23", CH_CR, ROW_LIT, CMD_VEL, 1, 0},
      '{"LEFT 1x2 3", CH_SP, 0, "", CH_LF, ROW_MODEL, CMD_NONE, 0, 0},
      '{"BACK ", 8'h0B, 1, "5", CH_LF, ROW_MODEL, CMD_NONE, 0, 0},
      '{"HEAD - 4", CH_SP, 0, "", CH_CR, ROW_MODEL, CMD_NONE, 0, 0},
      '{"VEL 1 2", CH_SP, 0, "", CH_CR, ROW_MODEL, CMD_NONE, 0, 0},
      '{"", CH_SP, 0, "", CH_LF, ROW_NONE, CMD_NONE, 0, 0},
      '{"RIGHT 7 -32769", CH_SP, 0, "", CH_LF, ROW_MODEL, CMD_NONE, 0, 0},
      '{"LEFT 99999", CH_SP, 0, "", CH_LF, ROW_MODEL, CMD_NONE, 0, 0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      r = directed_lines[i];
      keep = (r.kind == ROW_MODEL);
      for (j = 0; j < r.head.len(); j++) feed(r.head[j], keep);
      repeat (r.pad_n) feed(r.pad_ch, keep);
      for (j = 0; j < r.tail.len(); j++) feed(r.tail[j], keep);
      if (r.kind == ROW_LIT) begin
        lit.id = r.id;
        lit.arg1 = VALUE_W'(r.v1);
        lit.arg2 = VALUE_W'(r.v2);
        expected_cmds.push_back(lit);
      end
      feed(r.term, keep);
    end

    run_phase(32, 68, 1'b0, 10'd999, 10'd0);
    run_phase(68, 32, 1'b0, 10'd0, 10'd999);
    run_phase(0, 0, 1'b1, CFG_DATA_W'($urandom_range(999)), CFG_DATA_W'($urandom_range(999)));

    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ampar_pkg.sv
hdl/ampar_scan.sv
hdl/ascii_motion_command_parser.sv
hdl/ampar_checker.sv
bench/ascii_motion_command_parser_tb.sv
